@@ design/frps_pkg.sv @@
// Package with the shared constants, types and control structures of the phase scheduler.
`timescale 1ns / 1ps

package frps_pkg;

  localparam int MAX_AGENTS = 64;
  localparam int TIME_BITS  = 32;

  localparam int DRAW_BITS  = 6;
  localparam int AGENT_BITS = 6;
  localparam int TS_BITS    = 32;
  localparam int CFG_BITS   = 7;

  localparam int COUNT_BITS    = $clog2(MAX_AGENTS + 1);
  localparam int GRP_SIZE      = 8;
  localparam int GRP_IDX_BITS  = 3;
  localparam int GCNT_BITS     = 4;
  localparam int NUM_GROUPS    = (MAX_AGENTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GSEL_BITS     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int PAD_BITS      = NUM_GROUPS * GRP_SIZE;
  localparam int PICK_BITS     = GSEL_BITS + GRP_IDX_BITS;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);

  typedef enum logic [1:0] {
    PH_LOOK    = 2'd0,
    PH_COMPUTE = 2'd1,
    PH_MOVE    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_PREP   = 3'd1,
    ST_COUNT  = 3'd2,
    ST_SELECT = 3'd3,
    ST_EMIT   = 3'd4
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic count;
    logic select;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   out_free;
  } dp_status_t;

endpackage

@@ design/frps_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps

interface frps_in_if import frps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DRAW_BITS-1:0] random_draw;

  modport source (output valid, output random_draw, input ready);
  modport sink   (input valid, input random_draw, output ready);
endinterface

interface frps_out_if import frps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            phase;
  logic [AGENT_BITS-1:0] agent_index;
  logic [TS_BITS-1:0]    time_stamp;
  logic                  round_start;

  modport source (output valid, output phase, output agent_index, output time_stamp,
                  output round_start, input ready);
  modport sink   (input valid, input phase, input agent_index, input time_stamp,
                  input round_start, output ready);
endinterface

interface frps_cfg_if import frps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] agent_count;

  modport source (output valid, output agent_count, input ready);
  modport sink   (input valid, input agent_count, output ready);
endinterface

@@ design/fair_random_phase_scheduler_top.sv @@
// Top level of the fair random phase scheduler: controller, datapath and checks.
//
//   Channel  Role    Payload
//   in_if    sink    random_draw
//   out_if   source  phase, agent_index, time_stamp, round_start
//   cfg_if   sink    agent_count (always ready)
//
// A look item runs through pool refill and draw clamp, per-group population counts,
// group selection and the pick within the group, each in a state of its own.
// Compute and move items go straight from acceptance to the emit step. One item is in work at a time.
// The result register lets the next item be accepted while a result waits; the
// final step stalls until that register is free. Reset is synchronous and active low.
`timescale 1ns / 1ps

module fair_random_phase_scheduler_top import frps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  frps_in_if.sink    in_if,
  frps_out_if.source out_if,
  frps_cfg_if.sink   cfg_if
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_if.ready = in_ready;

  frps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  frps_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_draw (in_if.random_draw),
    .cmd     (cmd),
    .status  (status),
    .cfg_if  (cfg_if),
    .out_if  (out_if)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("A second item was accepted while one was in work.");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("A result was written over one not yet taken.");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.emit))
    else $error("A result appeared without an emit step.");

  a_phase_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.phase == PH_COMPUTE) |=> status.phase == PH_MOVE)
    else $error("The move phase did not follow the compute phase.");
`endif

endmodule

@@ design/frps_ctrl.sv @@
// Controller state machine that sequences the look, compute and move steps.
`timescale 1ns / 1ps

module frps_ctrl import frps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.phase == PH_COMPUTE || status.phase == PH_MOVE) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/frps_dp.sv @@
// Datapath holding the agent pool, the group counts, the event time and the result register.
`timescale 1ns / 1ps

module frps_dp import frps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [DRAW_BITS-1:0] in_draw,
  input  ctl_cmd_t             cmd,
  output dp_status_t           status,
  frps_cfg_if.sink             cfg_if,
  frps_out_if.source           out_if
);

  logic [CFG_BITS-1:0]    agent_count_r;
  logic [MAX_AGENTS-1:0]  pool_mask_r, pool_mask_nxt;
  logic [COUNT_BITS-1:0]  pool_count_r, pool_count_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [AGENT_BITS-1:0]  chosen_r, chosen_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [DRAW_BITS-1:0]   draw_r, draw_nxt;
  logic                   start_r, start_nxt;
  logic [GCNT_BITS-1:0]   grp_cnt_r [NUM_GROUPS];
  logic [GCNT_BITS-1:0]   grp_cnt_nxt [NUM_GROUPS];
  logic [GSEL_BITS-1:0]   grp_sel_r, grp_sel_nxt;
  logic [GRP_IDX_BITS-1:0] rank_r, rank_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_phase_r, out_phase_nxt;
  logic [AGENT_BITS-1:0]  out_agent_r, out_agent_nxt;
  logic [TS_BITS-1:0]     out_time_r, out_time_nxt;
  logic                   out_start_r, out_start_nxt;

  logic                   refill;
  logic [CFG_BITS-1:0]    fill_n;
  logic [CFG_BITS-1:0]    eff_cnt;
  logic [CFG_BITS-1:0]    acc;
  logic [CFG_BITS-1:0]    rank_ext;
  logic                   found;
  logic [PAD_BITS-1:0]    pad_mask;
  logic [GRP_SIZE-1:0]    grp_bits;
  logic [GCNT_BITS-1:0]   seen;
  logic [GRP_IDX_BITS-1:0] pos;
  logic                   pos_found;
  logic [PICK_BITS-1:0]   pick;
  logic [PAD_BITS-1:0]    pad_clear;

  assign cfg_if.ready    = 1'b1;
  assign status.phase    = phase_r;
  assign status.out_free = !out_valid_r || out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.phase       = out_phase_r;
  assign out_if.agent_index = out_agent_r;
  assign out_if.time_stamp  = out_time_r;
  assign out_if.round_start = out_start_r;

  always_comb begin
    pool_mask_nxt  = pool_mask_r;
    pool_count_nxt = pool_count_r;
    phase_nxt      = phase_r;
    chosen_nxt     = chosen_r;
    time_nxt       = time_r;
    draw_nxt       = draw_r;
    start_nxt      = start_r;
    grp_cnt_nxt    = grp_cnt_r;
    grp_sel_nxt    = grp_sel_r;
    rank_nxt       = rank_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_phase_nxt  = out_phase_r;
    out_agent_nxt  = out_agent_r;
    out_time_nxt   = out_time_r;
    out_start_nxt  = out_start_r;

    refill = (pool_count_r == '0) || (pool_mask_r == '0);
    if (agent_count_r == '0) begin
      fill_n = CFG_BITS'(1);
    end else if (agent_count_r > CFG_BITS'(MAX_AGENTS)) begin
      fill_n = CFG_BITS'(MAX_AGENTS);
    end else begin
      fill_n = agent_count_r;
    end
    eff_cnt = refill ? fill_n : CFG_BITS'(pool_count_r);

    pad_mask = PAD_BITS'(pool_mask_r);
    grp_bits = pad_mask[grp_sel_r * GRP_SIZE +: GRP_SIZE];

    acc      = '0;
    found    = 1'b0;
    rank_ext = CFG_BITS'(draw_r);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (!found && (rank_ext < acc + CFG_BITS'(grp_cnt_r[g]))) begin
        found = 1'b1;
        grp_sel_nxt = GSEL_BITS'(g);
        rank_nxt    = GRP_IDX_BITS'(rank_ext - acc);
      end
      acc = acc + CFG_BITS'(grp_cnt_r[g]);
    end
    if (!cmd.select) begin
      grp_sel_nxt = grp_sel_r;
      rank_nxt    = rank_r;
    end

    seen      = '0;
    pos       = '0;
    pos_found = 1'b0;
    for (int b = 0; b < GRP_SIZE; b++) begin
      if (grp_bits[b] && !pos_found) begin
        if (seen == GCNT_BITS'(rank_r)) begin
          pos       = GRP_IDX_BITS'(b);
          pos_found = 1'b1;
        end
        seen = seen + GCNT_BITS'(1);
      end
    end
    pick      = {grp_sel_r, pos};
    pad_clear = pad_mask & ~(PAD_BITS'(1) << pick);

    if (cmd.take) begin
      draw_nxt = in_draw;
    end

    if (cmd.prep) begin
      start_nxt = refill;
      if (refill) begin
        for (int i = 0; i < MAX_AGENTS; i++) begin
          pool_mask_nxt[i] = (CFG_BITS'(i) < fill_n);
        end
        pool_count_nxt = COUNT_BITS'(fill_n);
      end
      if (CFG_BITS'(draw_r) >= eff_cnt) begin
        draw_nxt = DRAW_BITS'(eff_cnt - CFG_BITS'(1));
      end
    end

    if (cmd.count) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_cnt_nxt[g] = '0;
        for (int b = 0; b < GRP_SIZE; b++) begin
          grp_cnt_nxt[g] = grp_cnt_nxt[g] + GCNT_BITS'(pad_mask[g * GRP_SIZE + b]);
        end
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_time_nxt  = TS_BITS'(time_r);
      unique case (phase_r)
        PH_COMPUTE: begin
          out_phase_nxt = PH_COMPUTE;
          out_agent_nxt = chosen_r;
          out_start_nxt = 1'b0;
          phase_nxt     = PH_MOVE;
        end
        PH_MOVE: begin
          out_phase_nxt = PH_MOVE;
          out_agent_nxt = '0;
          out_start_nxt = 1'b0;
          phase_nxt     = PH_LOOK;
          time_nxt      = time_r + TIME_BITS'(1);
        end
        default: begin
          out_phase_nxt  = PH_LOOK;
          out_agent_nxt  = AGENT_BITS'(pick);
          out_start_nxt  = start_r;
          chosen_nxt     = AGENT_BITS'(pick);
          pool_mask_nxt  = pad_clear[MAX_AGENTS-1:0];
          pool_count_nxt = pool_count_r - COUNT_BITS'(1);
          phase_nxt      = PH_COMPUTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_count_r <= CFG_RESET;
      pool_mask_r   <= '0;
      pool_count_r  <= '0;
      phase_r       <= PH_LOOK;
      chosen_r      <= '0;
      time_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        agent_count_r <= cfg_if.agent_count;
      end
      pool_mask_r  <= pool_mask_nxt;
      pool_count_r <= pool_count_nxt;
      phase_r      <= phase_nxt;
      chosen_r     <= chosen_nxt;
      time_r       <= time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    draw_r      <= draw_nxt;
    start_r     <= start_nxt;
    grp_cnt_r   <= grp_cnt_nxt;
    grp_sel_r   <= grp_sel_nxt;
    rank_r      <= rank_nxt;
    out_phase_r <= out_phase_nxt;
    out_agent_r <= out_agent_nxt;
    out_time_r  <= out_time_nxt;
    out_start_r <= out_start_nxt;
  end

endmodule
